[design/bfwm_pkg.sv]
// Package for the bounded FIFO with largest-value query.
// Holds the transaction structs, command and status codes, and defaults.
// No dependencies.
`default_nettype none

package bfwm_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_W         = 5;
  localparam int COUNT_OUT_W   = 5;
  localparam int WORD_W        = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam int                POP_GROUP = 3;
  localparam logic signed [WORD_W-1:0] MOST_NEG = 32'sh8000_0000;

  // Command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP1 = 2'd1;
  localparam logic [1:0] CMD_POP3 = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic signed [WORD_W-1:0] largest_value;
  } result_t;

endpackage

`default_nettype wire

[design/bounded_fifo_with_max.sv]
// Sequence: an accepted command is executed in S_EXEC, the held entries are then scanned in
// S_SCAN (skipped when none are held after the command), and the result is given in S_REPORT.
// A new command is not taken until the last one is through: busy stays high until the
// result cycle has passed. The scan reads the held entries through the single
// read port of the entry memory, one word per cycle into one shared comparator.
// Results cannot be stalled by the receiver.
// Reset (rst, synchronous, active high): FIFO empty, head at zero, capacity_limit 16.
`default_nettype none

module bounded_fifo_with_max #(
  parameter int DEPTH = bfwm_pkg::DEPTH_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  // command channel
  input  wire                              start,
  output logic                             busy,
  input  bfwm_pkg::cmd_t                   cmd,
  // result channel
  output logic                             done,
  output bfwm_pkg::result_t                result,
  // configuration channel (capacity_limit)
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [bfwm_pkg::CAP_W-1:0]        cfg_data
);

  import bfwm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // pointer width
  localparam int CW = $clog2(DEPTH + 1);                 // count width
  localparam int SW = PW + 2;                            // wrap sum width

  // Sequencer: take a command, execute it, scan the held entries, report.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t state, state_next;

  cmd_t                     cmd_q;
  logic [CAP_W-1:0]         capacity;
  logic [PW-1:0]            head, head_next;
  logic [CW-1:0]            count, count_next;
  logic [1:0]               status_q, status_next;

  // Scan datapath
  logic [PW-1:0]            scan_addr;
  logic [CW-1:0]            issued;
  logic [CW-1:0]            got;
  logic                     rd_en;
  logic                     rd_valid;
  logic signed [WORD_W-1:0] rd_data;
  logic signed [WORD_W-1:0] best;

  // Entry memory: contents undefined until written
  logic signed [WORD_W-1:0] mem [DEPTH];
  logic                     wr_en;
  logic [PW-1:0]            wr_addr;

  logic                     full;
  logic [CW-1:0]            pop_amt;

  // Add an offset to a pointer and wrap modulo DEPTH; the sum stays below 2*DEPTH.
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                             input logic [CW-1:0] offs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(offs);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_REPORT);
  assign cfg_ready = 1'b1;

  assign result.status        = status_q;
  assign result.entry_count   = COUNT_OUT_W'(count);
  assign result.largest_value = best;

  // Refuse a push at the programmed capacity or at the physical depth.
  assign full    = (32'(count) >= 32'(capacity)) || (32'(count) >= 32'(DEPTH));
  assign pop_amt = (32'(count) >= POP_GROUP) ? CW'(POP_GROUP) : count;
  assign wr_addr = wrap_add(head, count);

  // Command execution: pointer, count and status updates for the EXEC cycle.
  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = ST_DONE;
    wr_en       = 1'b0;
    unique case (cmd_q.command)
      CMD_PUSH: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      CMD_POP1: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          head_next  = wrap_add(head, CW'(1));
          count_next = count - CW'(1);
        end
      end
      CMD_POP3: begin
        if (32'(count) < POP_GROUP) begin
          status_next = ST_EMPTY;
        end
        head_next  = wrap_add(head, pop_amt);
        count_next = count - pop_amt;
      end
      default: begin
        // unused code: hold state, report as done
        status_next = ST_DONE;
      end
    endcase
  end

  // Issue one read per cycle until every held entry has been requested.
  assign rd_en = (state == S_SCAN) && (issued != count);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = (count_next == '0) ? S_REPORT : S_SCAN;
      end
      S_SCAN: begin
        if (rd_valid && (got + CW'(1) == count)) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      capacity <= CAP_RESET;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (state == S_EXEC) begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q <= cmd;
    end
    if (state == S_EXEC) begin
      status_q  <= status_next;
      scan_addr <= head_next;
      issued    <= '0;
      got       <= '0;
      best      <= MOST_NEG;
    end else if (state == S_SCAN) begin
      if (rd_en) begin
        scan_addr <= (scan_addr == PW'(DEPTH - 1)) ? '0 : scan_addr + PW'(1);
        issued    <= issued + CW'(1);
      end
      if (rd_valid) begin
        got <= got + CW'(1);
        if (rd_data > best) begin
          best <= rd_data;
        end
      end
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_EXEC && wr_en) begin
      mem[wr_addr] <= cmd_q.push_value;
    end
    if (rd_en) begin
      rd_data <= mem[scan_addr];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(DEPTH))
    else $error("held count exceeds depth");

  a_take_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && state == S_EXEC))
    else $error("accepted command did not enter execution");

  a_empty_max: assert property (@(posedge clk) disable iff (rst)
    (done && result.entry_count == '0) |-> (result.largest_value == MOST_NEG))
    else $error("empty FIFO reported a largest value other than most negative");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issued <= count && got <= issued))
    else $error("scan ran past the held entries");

  a_full_only_push: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> (cmd_q.command == CMD_PUSH))
    else $error("full status on a command other than push");
`endif

endmodule

`default_nettype wire
